// ===== rtl/core/sac_pkg.sv =====
// sac_pkg: shared widths, register indexes and codes for the sensor
// average and calibration block. No dependencies.

package sac_pkg;

  localparam int CODE_W   = 16;  // raw ADC sample
  localparam int REG_W    = 32;  // calibration registers and datapath
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W    = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BATT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_BIAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_BIAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_BIAS = 3'd5;

  // request kinds and channels
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam logic CH_BATT    = 1'b0;
  localparam logic CH_TEMP    = 1'b1;

  localparam logic signed [REG_W-1:0] TEMP_FLOOR = -32'sd127;

  typedef logic [REG_W-1:0] word_t;

endpackage

// ===== rtl/core/sensor_average_calibrate.sv =====
// sensor_average_calibrate: two-channel moving average with linear
// calibration. Depends on sac_pkg, sac_ram (sample rings), sac_mac.
//
//   channel   handshake                      payload
//   input     s_axis_tvalid / s_axis_tready  tuser {channel, op}, tdata sample_code
//   output    m_axis_tvalid / m_axis_tready  tuser result_channel, tdata values
//   config    cfg_we                         cfg_index, cfg_data
//
// A store writes one ring slot; the first sample of a channel instead fills every
// ring slot through the single RAM write port.
// A compute reads the ring one slot per cycle, then makes one pass through the
// shared multiply-add unit, or two for temperature. Compute on a never-sampled
// channel skips the ring reads and the passes and goes straight to the result.
// s_axis_tready is low while a request is in work and while a finished result
// waits for a stalled output. rst is synchronous; the rings need no clearing pass.

module sensor_average_calibrate
  import sac_pkg::*;
#(
  parameter int AVG_LOG2   = 4,
  parameter int GAIN_SHIFT = 16,
  parameter int TEMP_SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CODE_W-1:0]    s_axis_tdata,   // [15:0] sample_code
  input  logic [1:0]           s_axis_tuser,   // [0] op, [1] channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] battery_mv, [31:16] chip_temp_c, [32] value_valid,
  // [33] temp_clamped, [39:34] zero
  output logic [39:0]          m_axis_tdata,
  output logic                 m_axis_tuser,   // [0] result_channel
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int DEPTH  = 1 << AVG_LOG2;
  localparam int CNT_W  = AVG_LOG2 + 1;
  localparam int ADDR_W = AVG_LOG2 + 1;
  localparam int SUM_W  = CODE_W + AVG_LOG2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MAC1 = 3'd3;
  localparam logic [2:0] S_MAC2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  word_t batt_gain, batt_bias, adc_gain, adc_bias, temp_gain, temp_bias;

  logic [2:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [AVG_LOG2-1:0] batt_wr_pos, temp_wr_pos;
  logic                batt_seen, temp_seen;
  logic                rd_vld;
  logic                ch;
  logic                seen_q;
  logic [CODE_W-1:0]   code;
  logic [SUM_W-1:0]    acc;

  logic                accept, in_op, in_ch, in_seen, out_free, fin_load;
  logic [AVG_LOG2-1:0] in_pos;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [CODE_W-1:0]   ram_wdata, ram_rdata;

  logic  mac_en;
  word_t mac_gain, mac_x, mac_bias, mac_y;

  word_t           batt_v, temp_shr, temp_mag, temp_v;
  logic            temp_neg, temp_clamp;
  logic [OUT_W-1:0] batt_mv, chip_temp;
  logic [39:0]     out_data;

  assign in_op    = s_axis_tuser[0];
  assign in_ch    = s_axis_tuser[1];
  assign in_seen  = (in_ch == CH_TEMP) ? temp_seen : batt_seen;
  assign in_pos   = (in_ch == CH_TEMP) ? temp_wr_pos : batt_wr_pos;
  assign s_axis_tready = !rst && (state == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign fin_load = (state == S_FIN) && out_free;

  // ring writes: steady-state store straight from the request, or fill sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ch, cnt[AVG_LOG2-1:0]};
    ram_wdata = code;
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end else if (accept && in_op == OP_STORE && in_seen) begin
      ram_we    = 1'b1;
      ram_waddr = {in_ch, in_pos};
      ram_wdata = s_axis_tdata;
    end
  end

  assign ram_raddr = {ch, cnt[AVG_LOG2-1:0]};

  sac_ram #(
    .WIDTH (CODE_W),
    .DEPTH (2 * DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiply-add operand select
  always_comb begin
    mac_en   = 1'b0;
    mac_gain = (ch == CH_TEMP) ? adc_gain : batt_gain;
    mac_bias = (ch == CH_TEMP) ? adc_bias : batt_bias;
    mac_x    = REG_W'(acc[SUM_W-1:AVG_LOG2]);
    case (state)
      S_MAC1: begin
        mac_en = 1'b1;
      end
      S_MAC2: begin
        mac_en   = 1'b1;
        mac_gain = temp_gain;
        mac_bias = temp_bias;
        mac_x    = mac_y >> GAIN_SHIFT;
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  sac_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .gain (mac_gain),
    .x    (mac_x),
    .bias (mac_bias),
    .y    (mac_y)
  );

  // final scaling: battery logical shift, temperature sign-magnitude shift
  assign batt_v     = mac_y >> GAIN_SHIFT;
  assign temp_neg   = mac_y[REG_W-1] || (mac_y == '0);
  assign temp_mag   = (REG_W'(0) - mac_y) >> TEMP_SHIFT;
  assign temp_shr   = mac_y >> TEMP_SHIFT;
  assign temp_v     = temp_neg ? (REG_W'(0) - temp_mag) : temp_shr;
  assign temp_clamp = $signed(temp_v) <= TEMP_FLOOR;
  assign batt_mv    = batt_v[OUT_W-1:0];
  assign chip_temp  = temp_clamp ? TEMP_FLOOR[OUT_W-1:0] : temp_v[OUT_W-1:0];

  always_comb begin
    out_data     = '0;
    out_data[32] = seen_q;
    if (seen_q) begin
      if (ch == CH_TEMP) begin
        out_data[31:16] = chip_temp;
        out_data[33]    = temp_clamp;
      end else begin
        out_data[15:0]  = batt_mv;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      rd_vld        <= 1'b0;
      batt_wr_pos   <= '0;
      temp_wr_pos   <= '0;
      batt_seen     <= 1'b0;
      temp_seen     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      batt_gain     <= '0;
      batt_bias     <= '0;
      adc_gain      <= '0;
      adc_bias      <= '0;
      temp_gain     <= '0;
      temp_bias     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BATT_GAIN: batt_gain <= cfg_data;
          REG_BATT_BIAS: batt_bias <= cfg_data;
          REG_ADC_GAIN:  adc_gain  <= cfg_data;
          REG_ADC_BIAS:  adc_bias  <= cfg_data;
          REG_TEMP_GAIN: temp_gain <= cfg_data;
          REG_TEMP_BIAS: temp_bias <= cfg_data;
          default: ;
        endcase
      end

      if (fin_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      rd_vld <= (state == S_SUM) && (cnt != CNT_W'(DEPTH));

      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            if (in_op == OP_STORE) begin
              if (!in_seen) begin
                state <= S_FILL;
                if (in_ch == CH_TEMP) begin
                  temp_seen   <= 1'b1;
                  temp_wr_pos <= AVG_LOG2'(1);
                end else begin
                  batt_seen   <= 1'b1;
                  batt_wr_pos <= AVG_LOG2'(1);
                end
              end else if (in_ch == CH_TEMP) begin
                temp_wr_pos <= temp_wr_pos + 1'b1;
              end else begin
                batt_wr_pos <= batt_wr_pos + 1'b1;
              end
            end else begin
              state <= in_seen ? S_SUM : S_FIN;
            end
          end
        end
        S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt[AVG_LOG2-1:0] == {AVG_LOG2{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          // last read data lands in the cycle the count reaches the depth
          if (cnt == CNT_W'(DEPTH)) begin
            state <= S_MAC1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MAC1: begin
          state <= (ch == CH_TEMP) ? S_MAC2 : S_FIN;
        end
        S_MAC2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ch     <= in_ch;
      code   <= s_axis_tdata;
      seen_q <= in_seen;
      acc    <= '0;
    end else if (rd_vld) begin
      acc <= acc + SUM_W'(ram_rdata);
    end
    if (fin_load) begin
      m_axis_tuser <= ch;
      m_axis_tdata <= out_data;
    end
  end

endmodule

// ===== rtl/core/sac_ram.sv =====
// sac_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module sac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sac_mac.sv =====
// sac_mac: shared multiply-add unit, gain * x + bias modulo 2^32, registered.
// Depends on sac_pkg.

module sac_mac
  import sac_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t gain,
  input  word_t x,
  input  word_t bias,
  output word_t y
);

  logic [2*REG_W-1:0] prod;

  assign prod = {{REG_W{1'b0}}, gain} * {{REG_W{1'b0}}, x};

  always_ff @(posedge clk) begin
    if (en) begin
      y <= prod[REG_W-1:0] + bias;
    end
  end

endmodule

// ===== tb/tb_sensor_average_calibrate.sv =====
// Self-checking bench for sensor_average_calibrate: directed table, then random
// phases at several calibration settings with random idling on both streams.
// Depends on sac_pkg and the RTL of the block; reads no files.

module tb_sensor_average_calibrate;
  import sac_pkg::*;

  localparam int AVG_LOG2    = 4;
  localparam int GAIN_SHIFT  = 16;
  localparam int TEMP_SHIFT  = 16;
  localparam int DEPTH       = 1 << AVG_LOG2;
  localparam int SETTLE      = 40;    // covers a first-sample ring fill or a compute
  localparam int HOLD_CYCLES = 400;
  localparam int N_DIR       = 31;
  localparam int N_PHASES    = 6;
  localparam int PHASE_REQS  = 75;

  typedef struct packed {
    logic              ch;
    logic [OUT_W-1:0]  mv;
    logic [OUT_W-1:0]  temp;
    logic              valid;
    logic              clamped;
  } reading_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   op;
    logic                   ch;
    logic [CODE_W-1:0]      code;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [REG_W-1:0]       reg_val;
    logic                   typed;    // want holds the expected reading
    reading_t               want;
  } dir_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_LIST [6] = '{REG_BATT_GAIN, REG_BATT_BIAS,
    REG_ADC_GAIN, REG_ADC_BIAS, REG_TEMP_GAIN, REG_TEMP_BIAS};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CODE_W-1:0]    s_axis_tdata = '0;   // [15:0] sample_code
  logic [1:0]           s_axis_tuser = '0;   // [0] op, [1] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [15:0] battery_mv, [31:16] chip_temp_c, [32] value_valid, [33] temp_clamped
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tuser;        // [0] result_channel
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [CODE_W-1:0]    ring [2][DEPTH];
  logic [AVG_LOG2-1:0]  wr_pos [2];
  logic                 seen [2];
  logic [REG_W-1:0]     cal_reg [8];

  reading_t  pending_readings [$];
  dir_row_t  dir_rows [N_DIR];
  int        n_miss = 0;
  int        rx_hold = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;
  bit        offering = 1'b0;

  sensor_average_calibrate #(
    .AVG_LOG2(AVG_LOG2), .GAIN_SHIFT(GAIN_SHIFT), .TEMP_SHIFT(TEMP_SHIFT)
  ) DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic void store_sample(logic ch, logic [CODE_W-1:0] code);
    if (!seen[ch]) begin
      for (int i = 0; i < DEPTH; i++) ring[ch][i] = code;
      seen[ch] = 1'b1;
      wr_pos[ch] = AVG_LOG2'(1);
    end else begin
      ring[ch][wr_pos[ch]] = code;
      wr_pos[ch] = wr_pos[ch] + 1'b1;
    end
  endfunction

  function automatic logic [REG_W-1:0] ring_avg(logic ch);
    logic [REG_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < DEPTH; i++) sum = sum + ring[ch][i];
    return sum >> AVG_LOG2;
  endfunction

  function automatic reading_t calibrate(logic ch);
    reading_t r;
    logic [REG_W-1:0] v, mag;
    r = '0;
    r.ch = ch;
    if (!seen[ch]) return r;
    r.valid = 1'b1;
    if (ch == CH_BATT) begin
      v = (cal_reg[REG_BATT_GAIN] * ring_avg(ch) + cal_reg[REG_BATT_BIAS]) >> GAIN_SHIFT;
      r.mv = v[OUT_W-1:0];
      return r;
    end
    v = (cal_reg[REG_ADC_GAIN] * ring_avg(ch) + cal_reg[REG_ADC_BIAS]) >> GAIN_SHIFT;
    v = cal_reg[REG_TEMP_GAIN] * v + cal_reg[REG_TEMP_BIAS];
    // sign-magnitude shift: rounds toward zero, zero takes the negative path
    if ($signed(v) <= 0) begin
      mag = (32'd0 - v) >> TEMP_SHIFT;
      v = 32'd0 - mag;
    end else begin
      v = v >> TEMP_SHIFT;
    end
    if ($signed(v) <= TEMP_FLOOR) begin
      r.temp = TEMP_FLOOR[OUT_W-1:0];
      r.clamped = 1'b1;
    end else begin
      r.temp = v[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic void predict(logic op, logic ch, logic [CODE_W-1:0] code);
    if (op == OP_STORE) store_sample(ch, code);
    else pending_readings.push_back(calibrate(ch));
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic dir_row_t req_row(logic op, logic ch, logic [CODE_W-1:0] code);
    dir_row_t d;
    d = '0;
    d.kind = ROW_REQ;
    d.op = op;
    d.ch = ch;
    d.code = code;
    return d;
  endfunction

  function automatic dir_row_t probe_row(logic ch, logic [15:0] mv, logic [15:0] temp,
                                         logic valid, logic clamped);
    dir_row_t d;
    d = req_row(OP_COMPUTE, ch, '0);
    d.typed = 1'b1;
    d.want = '{ch, mv, temp, valid, clamped};
    return d;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_REG;
    d.reg_idx = idx;
    d.reg_val = val;
    return d;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return CODE_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      5: return $urandom_range(0, 32'h0002_0000);
      6: return 32'd0 - $urandom_range(0, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(logic op, logic ch, logic [CODE_W-1:0] code);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {ch, op};
    s_axis_tdata <= code;
    offering = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drop_req();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic pause();
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      drop_req();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    drop_req();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cal_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------- result side ----------------
  function automatic void note_miss(string what, logic [39:0] want, logic [39:0] got);
    n_miss++;
    if (n_miss <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endfunction

  always @(posedge clk) begin : rx_side
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      rdy = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      rx_hold = HOLD_CYCLES - 1;
      rdy = 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      rx_hold = gap_len();
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk) begin : result_check
    reading_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[32],
              m_axis_tdata[33]};
      if (pending_readings.size() == 0) begin
        note_miss("result with nothing pending", '0, 40'(got));
      end else begin
        want = pending_readings.pop_front();
        if (got.ch !== want.ch)
          note_miss("result_channel", 40'(want.ch), 40'(got.ch));
        if (got.mv !== want.mv)
          note_miss("battery_mv", 40'(want.mv), 40'(got.mv));
        if (got.temp !== want.temp)
          note_miss("chip_temp_c", 40'(want.temp), 40'(got.temp));
        if (got.valid !== want.valid)
          note_miss("value_valid", 40'(want.valid), 40'(got.valid));
        if (got.clamped !== want.clamped)
          note_miss("temp_clamped", 40'(want.clamped), 40'(got.clamped));
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin : main
    logic op, ch;
    for (int c = 0; c < 2; c++) begin
      seen[c] = 1'b0;
      wr_pos[c] = '0;
    end
    foreach (cal_reg[i]) cal_reg[i] = '0;

    dir_rows = '{
      probe_row(CH_BATT, 16'h0000, 16'h0000, 1'b0, 1'b0),   // never sampled
      probe_row(CH_TEMP, 16'h0000, 16'h0000, 1'b0, 1'b0),
      req_row(OP_STORE, CH_BATT, 16'hFFFF),                 // first sample fills ring
      probe_row(CH_BATT, 16'h0000, 16'h0000, 1'b1, 1'b0),   // zero gain after reset
      req_row(OP_STORE, CH_TEMP, 16'h0000),
      probe_row(CH_TEMP, 16'h0000, 16'h0000, 1'b1, 1'b0),   // zero second stage
      reg_row(REG_BATT_GAIN, 32'h0001_0000),
      probe_row(CH_BATT, 16'hFFFF, 16'h0000, 1'b1, 1'b0),
      req_row(OP_STORE, CH_BATT, 16'h0000),
      req_row(OP_COMPUTE, CH_BATT, 16'h0000),
      reg_row(REG_BATT_BIAS, 32'hFFFF_FFFF),
      req_row(OP_COMPUTE, CH_BATT, 16'h0000),
      reg_row(REG_ADC_GAIN, 32'h0001_0000),
      reg_row(REG_TEMP_GAIN, 32'h0001_0000),
      // temp ring is all zero, so the second stage equals temp_bias
      reg_row(REG_TEMP_BIAS, 32'h8000_0000),
      probe_row(CH_TEMP, 16'h0000, 16'hFF81, 1'b1, 1'b1),   // most negative
      reg_row(REG_TEMP_BIAS, 32'h7FFF_FFFF),
      probe_row(CH_TEMP, 16'h0000, 16'h7FFF, 1'b1, 1'b0),
      reg_row(REG_TEMP_BIAS, 32'hFF81_0000),
      probe_row(CH_TEMP, 16'h0000, 16'hFF81, 1'b1, 1'b1),   // exactly at floor
      reg_row(REG_TEMP_BIAS, 32'hFF82_0000),
      probe_row(CH_TEMP, 16'h0000, 16'hFF82, 1'b1, 1'b0),   // just above floor
      reg_row(REG_TEMP_BIAS, 32'hFFFF_FFFF),
      probe_row(CH_TEMP, 16'h0000, 16'h0000, 1'b1, 1'b0),   // rounds toward zero
      reg_row(REG_ADC_BIAS, 32'h7FFF_FFFF),
      req_row(OP_STORE, CH_TEMP, 16'hFFFF),
      req_row(OP_COMPUTE, CH_TEMP, 16'h0000),
      req_row(OP_STORE, CH_TEMP, 16'h1234),
      req_row(OP_COMPUTE, CH_TEMP, 16'h0000),
      req_row(OP_STORE, CH_BATT, 16'h8000),
      req_row(OP_COMPUTE, CH_BATT, 16'h0000)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_req(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].code);
        if (dir_rows[i].typed) pending_readings.push_back(dir_rows[i].want);
        else predict(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].code);
        pause();
      end
    end

    // random phases: all-max, all-min, then mixed settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      foreach (REG_LIST[r])
        set_reg(REG_LIST[r], ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000 : pick_word());
      no_idle = (ph == 2);
      if (ph == 3) hold_req = 1'b1;   // long output stall, input keeps coming
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (ph == 4 && k == PHASE_REQS / 2) wait_idle();
        op = $urandom_range(0, 1);
        ch = $urandom_range(0, 1);
        send_req(op, ch, pick_code());
        predict(op, ch, s_axis_tdata);
        pause();
      end
      no_idle = 1'b0;
    end

    wait_idle();
    if (n_miss == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sac_pkg.sv
rtl/core/sac_ram.sv
rtl/core/sac_mac.sv
rtl/core/sensor_average_calibrate.sv
tb/tb_sensor_average_calibrate.sv
